@@ sv/ckv_pkg.sv @@
package ckv_pkg;

  // table geometry
  localparam int BUCKETS        = 256;
  localparam int BKT_W          = 8;
  localparam int WAYS           = 4;
  localparam int WAY_W          = 2;
  localparam int VALUES_PER_KEY = 4;
  localparam int KEY_BYTES      = 8;
  localparam int MAX_RESULTS    = 4;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 3;
  localparam int META_W  = 1 + CNT_W;
  localparam int TOT_W   = 13;
  localparam int ROW_W   = VALUES_PER_KEY * VAL_W;
  localparam int ENT_W   = BKT_W + WAY_W;

  localparam logic [63:0]      CRC_POLY  = 64'hC96C5795D7870F42;
  localparam logic [63:0]      CRC_INIT  = 64'hFFFFFFFFFFFFFFFF;
  localparam logic [TOT_W-1:0] TOTAL_MAX = 13'd8191;

  // configuration register indexes
  localparam logic [1:0] REG_MULTI_MODE = 2'd0;
  localparam logic [1:0] REG_KEY_BYTES  = 2'd1;
  localparam logic [1:0] REG_TABLE_BITS = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_REM_ONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_WRONG     = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HASH = 6'b000010,
    S_ADDR = 6'b000100,
    S_BKT  = 6'b001000,
    S_VAL  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } crc_ctrl_t;

  // one byte of reflected crc-64
  function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
    logic [63:0] c;
    c = crc ^ {56'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 64'd0);
    end
    return c;
  endfunction

endpackage

@@ sv/ckv_ram.sv @@
module ckv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/ckv_crc_unit.sv @@
module ckv_crc_unit import ckv_pkg::*; (
  input  logic        clk,
  input  crc_ctrl_t   ctrl,
  input  logic [7:0]  data_byte,
  output logic [63:0] crc
);

  logic [63:0] crc_r;
  logic [63:0] crc_nxt;

  // load start value or fold in one key byte
  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.start) begin
      crc_nxt = CRC_INIT;
    end else if (ctrl.step) begin
      crc_nxt = crc64_byte(crc_r, data_byte);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

@@ sv/crc64_hashed_key_value_table.sv @@
// Key/value table hashed by reflected crc-64 (ECMA-182). A command takes one beat
// on the input and returns one to four result beats; in_tready is low until the
// last result beat is taken. Each command steps through S_IDLE (accept), S_HASH
// (key_bytes bytes, 1..8, in the byte-serial crc unit), S_ADDR (bucket address),
// S_BKT (bucket read of keys and way status), S_VAL (value-row read and
// write-back) and S_EMIT (result beats, each held until taken). No clearing pass
// is needed after reset; a per-bucket flag marks rows whose way status has been
// written.
module crc64_hashed_key_value_table import ckv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // cmd[1:0], key[65:2], value[129:66], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // status[1:0], found_value[65:2], total_count[78:66]
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [3:0]   cfg_data
);

  state_t state_r, state_nxt;

  // configuration
  logic       multi_r;
  logic [3:0] kbytes_r;
  logic [3:0] tbits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      multi_r  <= 1'b0;
      kbytes_r <= 4'd8;
      tbits_r  <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MULTI_MODE: multi_r  <= cfg_data[0];
        REG_KEY_BYTES:  kbytes_r <= cfg_data;
        REG_TABLE_BITS: tbits_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // bytes in use and key mask
  logic [3:0]       nb;
  logic [KEY_W-1:0] km;
  always_comb begin
    nb = kbytes_r;
    if (nb == 4'd0) nb = 4'd1;
    if (nb > 4'(KEY_BYTES)) nb = 4'(KEY_BYTES);
    for (int j = 0; j < 8; j++) begin
      km[8*j +: 8] = (4'(j) < nb) ? 8'hFF : 8'h00;
    end
  end

  // command registers
  logic [1:0]       cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic [KEY_W-1:0] km_r;
  logic [3:0]       nb_r;
  logic [2:0]       byte_idx_r;
  logic             in_fire, out_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_tdata[1:0];
      key_r   <= in_tdata[65:2] & km;
      value_r <= in_tdata[129:66];
      km_r    <= km;
      nb_r    <= nb;
    end
  end

  // crc unit, one key byte a cycle
  crc_ctrl_t   crc_ctrl;
  logic [63:0] crc;
  assign crc_ctrl.start = in_fire;
  assign crc_ctrl.step  = (state_r == S_HASH);

  ckv_crc_unit u_crc (
    .clk       (clk),
    .ctrl      (crc_ctrl),
    .data_byte (key_r[{byte_idx_r, 3'b000} +: 8]),
    .crc       (crc)
  );

  logic hash_done;
  assign hash_done = ({1'b0, byte_idx_r} == (nb_r - 4'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= '0;
    end else if (in_fire) begin
      byte_idx_r <= '0;
    end else if (state_r == S_HASH) begin
      byte_idx_r <= byte_idx_r + 3'd1;
    end
  end

  // bucket from masked hash
  logic [BKT_W-1:0] bucket, bucket_r;
  always_comb begin
    for (int j = 0; j < BKT_W; j++) begin
      bucket[j] = crc[j] & (4'(j) < tbits_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ADDR) bucket_r <= bucket;
  end

  // memories
  logic                    meta_we, key_we, val_we;
  logic [WAYS*META_W-1:0]  meta_rd, meta_wr;
  logic [WAYS*KEY_W-1:0]   key_rd, key_wr;
  logic [ROW_W-1:0]        val_rd, val_wr;
  logic [WAY_W-1:0]        way_sel, tgt_way;

  ckv_ram #(.WIDTH(WAYS*META_W), .DEPTH(BUCKETS)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(bucket_r), .wdata(meta_wr),
    .raddr(bucket), .rdata(meta_rd)
  );

  ckv_ram #(.WIDTH(WAYS*KEY_W), .DEPTH(BUCKETS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(bucket_r), .wdata(key_wr),
    .raddr(bucket), .rdata(key_rd)
  );

  ckv_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS*WAYS)) u_val_ram (
    .clk(clk), .we(val_we), .waddr({bucket_r, tgt_way}), .wdata(val_wr),
    .raddr({bucket_r, way_sel}), .rdata(val_rd)
  );

  // buckets whose status row was ever written
  logic [BUCKETS-1:0] row_init_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (meta_we) begin
      row_init_r[bucket_r] <= 1'b1;
    end
  end

  // way search over the bucket
  logic [WAYS*META_W-1:0] meta_eff;
  logic                   hit, free_ok;
  logic [WAY_W-1:0]       free_way;
  always_comb begin
    meta_eff = row_init_r[bucket_r] ? meta_rd : '0;
    hit      = 1'b0;
    way_sel  = '0;
    free_ok  = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && meta_eff[w*META_W] && ((key_rd[w*KEY_W +: KEY_W] & km_r) == key_r)) begin
        hit     = 1'b1;
        way_sel = WAY_W'(w);
      end
      if (!free_ok && !meta_eff[w*META_W]) begin
        free_ok  = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  logic [WAYS*META_W-1:0] meta_row_r;
  logic [WAYS*KEY_W-1:0]  key_row_r;
  logic                   hit_r, free_ok_r;
  logic [WAY_W-1:0]       way_r, free_way_r;

  always_ff @(posedge clk) begin
    if (state_r == S_BKT) begin
      meta_row_r <= meta_eff;
      key_row_r  <= key_rd;
      hit_r      <= hit;
      free_ok_r  <= free_ok;
      way_r      <= way_sel;
      free_way_r <= free_way;
    end
  end

  // command execution and write-back
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [1:0]         status_nxt;
  logic [VAL_W-1:0]   res_val_nxt [MAX_RESULTS];
  logic [2:0]         res_cnt_nxt;
  logic [CNT_W-1:0]   ent_cnt, cnt;
  logic               found;
  logic [WAY_W-1:0]   pos;
  logic [TOT_W:0]     tsum;

  assign tgt_way = hit_r ? way_r : free_way_r;
  assign ent_cnt = meta_row_r[way_r*META_W+1 +: CNT_W];
  assign cnt     = (ent_cnt > CNT_W'(VALUES_PER_KEY)) ? CNT_W'(VALUES_PER_KEY) : ent_cnt;
  assign tsum    = {1'b0, total_r} + 14'd1;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < VALUES_PER_KEY; i++) begin
      if (!found && (CNT_W'(i) < cnt) && (val_rd[i*VAL_W +: VAL_W] == value_r)) begin
        found = 1'b1;
        pos   = WAY_W'(i);
      end
    end
  end

  always_comb begin
    meta_we     = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    meta_wr     = meta_row_r;
    key_wr      = key_row_r;
    val_wr      = val_rd;
    total_nxt   = total_r;
    status_nxt  = ST_OK;
    res_cnt_nxt = 3'd1;
    for (int k = 0; k < MAX_RESULTS; k++) res_val_nxt[k] = '0;
    if (state_r == S_VAL) begin
      unique case (cmd_r)
        CMD_SET: begin
          if (hit_r && !multi_r) begin
            val_we = 1'b1;
            val_wr[VAL_W-1:0] = value_r;
            if (ent_cnt == '0) begin
              meta_we = 1'b1;
              meta_wr[way_r*META_W+1 +: CNT_W] = CNT_W'(1);
            end
          end else if (hit_r) begin
            if (cnt >= CNT_W'(VALUES_PER_KEY)) begin
              status_nxt = ST_FULL;
            end else begin
              val_we  = 1'b1;
              val_wr  = {val_rd[ROW_W-VAL_W-1:0], value_r};
              meta_we = 1'b1;
              meta_wr[way_r*META_W+1 +: CNT_W] = cnt + CNT_W'(1);
              total_nxt = (tsum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tsum[TOT_W-1:0];
            end
          end else if (!free_ok_r) begin
            status_nxt = ST_FULL;
          end else begin
            val_we = 1'b1;
            val_wr[VAL_W-1:0] = value_r;
            key_we = 1'b1;
            key_wr[free_way_r*KEY_W +: KEY_W] = key_r;
            meta_we = 1'b1;
            meta_wr[free_way_r*META_W +: META_W] = {CNT_W'(1), 1'b1};
            total_nxt = (tsum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tsum[TOT_W-1:0];
          end
        end
        CMD_REMOVE: begin
          if (!hit_r) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            meta_we = 1'b1;
            meta_wr[way_r*META_W +: META_W] = '0;
            if (multi_r) begin
              total_nxt = (total_r > TOT_W'(cnt)) ? total_r - TOT_W'(cnt) : '0;
            end else begin
              total_nxt = (total_r > TOT_W'(1)) ? total_r - TOT_W'(1) : '0;
            end
          end
        end
        CMD_REM_ONE: begin
          if (!multi_r) begin
            status_nxt = ST_WRONG;
          end else if (!hit_r || !found) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            val_we = 1'b1;
            for (int j = 0; j < VALUES_PER_KEY - 1; j++) begin
              if (WAY_W'(j) >= pos) val_wr[j*VAL_W +: VAL_W] = val_rd[(j+1)*VAL_W +: VAL_W];
            end
            meta_we = 1'b1;
            meta_wr[way_r*META_W+1 +: CNT_W] = cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) meta_wr[way_r*META_W +: META_W] = '0;
            total_nxt = (total_r > TOT_W'(1)) ? total_r - TOT_W'(1) : '0;
          end
        end
        CMD_LOOKUP: begin
          if (!hit_r || cnt == '0) begin
            status_nxt = ST_NOT_FOUND;
          end else if (!multi_r) begin
            res_val_nxt[0] = val_rd[VAL_W-1:0];
          end else begin
            res_cnt_nxt = (cnt > 3'(MAX_RESULTS)) ? 3'(MAX_RESULTS) : cnt;
            for (int k = 0; k < MAX_RESULTS; k++) res_val_nxt[k] = val_rd[k*VAL_W +: VAL_W];
          end
        end
        default: ;
      endcase
    end
  end

  // result registers
  logic [1:0]       res_status_r;
  logic [VAL_W-1:0] res_val_r [MAX_RESULTS];
  logic [2:0]       res_cnt_r;
  logic [1:0]       res_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      res_idx_r <= '0;
      res_cnt_r <= 3'd1;
    end else if (state_r == S_VAL) begin
      total_r   <= total_nxt;
      res_idx_r <= '0;
      res_cnt_r <= res_cnt_nxt;
    end else if (out_fire) begin
      res_idx_r <= res_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_VAL) begin
      res_status_r <= status_nxt;
      for (int k = 0; k < MAX_RESULTS; k++) res_val_r[k] <= res_val_nxt[k];
    end
  end

  assign out_tvalid = (state_r == S_EMIT);
  assign out_tlast  = ({1'b0, res_idx_r} == (res_cnt_r - 3'd1));
  assign out_tdata  = {1'b0, total_r, res_val_r[res_idx_r], res_status_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_HASH;
      S_HASH: if (hash_done) state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_BKT;
      S_BKT:  state_nxt = S_VAL;
      S_VAL:  state_nxt = S_EMIT;
      S_EMIT: if (out_fire && out_tlast) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("input taken while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accepting while results pending");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, res_idx_r} < res_cnt_r)) else $error("result index overrun");

  a_hash_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HASH) |-> ({1'b0, byte_idx_r} < nb_r)) else $error("hash ran past key");

endmodule
